### sv/interval_union_set_unit_defines.svh
// assertion macros for the interval union set unit
// expects clk and rst_n in the scope of each use
`ifndef INTERVAL_UNION_SET_UNIT_DEFINES_SVH
`define INTERVAL_UNION_SET_UNIT_DEFINES_SVH

// same-cycle implication
`define IUS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication
`define IUS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

### sv/ius_pkg.sv
// shared types and constants for the interval union set unit
// no dependencies
`default_nettype none

package ius_pkg;

    localparam int MAX_RANGES = 16;
    localparam int COORD_BITS = 22;
    localparam int IDX_BITS   = $clog2(MAX_RANGES);
    localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);
    localparam int SUM_BITS   = COORD_BITS + 1;
    localparam int ENTRY_BITS = 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SUM_BITS-1:0]   sum_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [IDX_BITS-1:0]   idx_t;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_REVERSED = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic start;
        logic eval;
        logic ent_valid;
        idx_t idx;
    } merge_ctl_t;

    typedef struct packed
    {
        logic   hit;
        logic   free_found;
        idx_t   free_idx;
        coord_t m_lo;
        coord_t m_hi;
        sum_t   removed;
        cnt_t   cleared;
    } merge_stat_t;

endpackage

`default_nettype wire

### sv/ius_if.sv
// item channels of the interval union set unit
// depends on ius_pkg
`default_nettype none

interface ius_req_if import ius_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   operation;
    coord_t lo;
    coord_t hi;

    modport source (output valid, operation, lo, hi, input ready);
    modport sink (input valid, operation, lo, hi, output ready);
    modport monitor (input valid, ready, operation, lo, hi);
endinterface

interface ius_rsp_if import ius_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        covered;
    sum_t        total_covered;
    cnt_t        range_count;
    logic [1:0]  status;

    modport source (output valid, covered, total_covered, range_count, status, input ready);
    modport sink (input valid, covered, total_covered, range_count, status, output ready);
    modport monitor (input valid, ready, covered, total_covered, range_count, status);
endinterface

`default_nettype wire

### sv/interval_union_set_unit.sv
// A query or insert item is accepted in ST_IDLE, then every entry is streamed
// out of the single read port of the range memory in ST_SCAN, the merged range
// is written back in ST_WRITE (inserts only) and the result register is loaded
// in ST_DONE. A reversed insert skips the scan and goes straight to ST_DONE. The
// next item is taken once the current result is loaded; a result waiting
// in the output register does not hold up the next item's scan.
// depends on ius_pkg, ius_if, ius_ram, ius_merge
`default_nettype none

module interval_union_set_unit import ius_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    ius_req_if.sink   req,
    ius_rsp_if.source rsp
);

    state_t                  state_reg;
    state_t                  state_next;
    idx_t                    rd_addr_reg;
    logic                    issue_reg;
    logic                    proc_reg;
    idx_t                    proc_idx_reg;
    logic                    query_reg;
    logic                    rev_reg;
    logic [MAX_RANGES-1:0]   valid_reg;
    sum_t                    sum_reg;
    cnt_t                    count_reg;

    logic                    out_valid_reg;
    logic                    covered_reg;
    sum_t                    total_reg;
    cnt_t                    range_count_reg;
    status_t                 status_reg;

    logic                    accept;
    logic                    is_query;
    logic                    is_rev;
    logic                    rd_en;
    logic                    wr_en;
    logic                    out_load;
    logic                    last_issue;
    logic                    last_proc;
    logic                    clear;
    merge_ctl_t              ctl;
    merge_stat_t             stat;
    logic [ENTRY_BITS-1:0]   rd_data;
    sum_t                    new_len;
    status_t                 status_now;

    assign accept     = req.valid && req.ready;
    assign is_query   = (req.operation == OP_QUERY);
    assign is_rev     = !is_query && (req.lo > req.hi);
    assign last_issue = (rd_addr_reg == idx_t'(MAX_RANGES - 1));
    assign last_proc  = proc_reg && (proc_idx_reg == idx_t'(MAX_RANGES - 1));
    assign new_len    = {1'b0, stat.m_hi} - {1'b0, stat.m_lo} + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_rev ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_proc)
                begin
                    state_next = query_reg ? ST_DONE : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req.ready = 1'b1;
            ST_SCAN:  rd_en     = issue_reg;
            ST_WRITE: wr_en     = stat.free_found;
            ST_DONE:  out_load  = !out_valid_reg || rsp.ready;
            default:  req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // each entry is evaluated in the cycle after its read is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg  <= '0;
            issue_reg    <= 1'b0;
            proc_reg     <= 1'b0;
            proc_idx_reg <= '0;
            query_reg    <= 1'b0;
            rev_reg      <= 1'b0;
        end
        else
        begin
            proc_reg     <= rd_en;
            proc_idx_reg <= rd_addr_reg;
            if (accept)
            begin
                rd_addr_reg <= '0;
                issue_reg   <= !is_rev;
                query_reg   <= is_query;
                rev_reg     <= is_rev;
            end
            else if (rd_en)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
                issue_reg   <= !last_issue;
            end
        end
    end

    assign ctl.start     = accept;
    assign ctl.eval      = proc_reg;
    assign ctl.ent_valid = valid_reg[proc_idx_reg];
    assign ctl.idx       = proc_idx_reg;

    ius_ram #(
        .DEPTH (MAX_RANGES),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (stat.free_idx),
        .wr_data ({stat.m_lo, stat.m_hi}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    ius_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .query     (is_query),
        .lo        (req.lo),
        .hi        (req.hi),
        .ent_start (rd_data[ENTRY_BITS-1 -: COORD_BITS]),
        .ent_end   (rd_data[COORD_BITS-1:0]),
        .clear     (clear),
        .stat      (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg[proc_idx_reg] <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[stat.free_idx] <= 1'b1;
                sum_reg   <= sum_reg - stat.removed + new_len;
                count_reg <= count_reg - stat.cleared + 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (rev_reg)
        begin
            status_now = STATUS_REVERSED;
        end
        else if (!query_reg && !stat.free_found)
        begin
            status_now = STATUS_FULL;
        end
        else
        begin
            status_now = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            covered_reg     <= query_reg && stat.hit;
            total_reg       <= sum_reg;
            range_count_reg <= count_reg;
            status_reg      <= status_now;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.covered       = covered_reg;
    assign rsp.total_covered = total_reg;
    assign rsp.range_count   = range_count_reg;
    assign rsp.status        = status_reg;

endmodule

`default_nettype wire

### sv/ius_ram.sv
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module ius_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 44
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/ius_merge.sv
// per-entry compare and merge accumulator, fed one stored range a cycle
// depends on ius_pkg
`default_nettype none

module ius_merge import ius_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire merge_ctl_t  ctl,
    input  wire logic        query,
    input  wire coord_t      lo,
    input  wire coord_t      hi,
    input  wire coord_t      ent_start,
    input  wire coord_t      ent_end,
    output logic             clear,
    output merge_stat_t      stat
);

    logic   query_reg;
    coord_t lo_reg;
    coord_t hi_reg;
    coord_t m_lo_reg;
    coord_t m_hi_reg;
    logic   hit_reg;
    logic   free_found_reg;
    idx_t   free_idx_reg;
    sum_t   removed_reg;
    cnt_t   cleared_reg;

    logic   meet;
    logic   in_span;
    sum_t   len;

    // touching counts too: adjacency is widened by one on each side
    assign meet = ({1'b0, ent_start} <= ({1'b0, hi_reg} + 1'b1))
               && (({1'b0, ent_end} + 1'b1) >= {1'b0, lo_reg});
    assign in_span = (ent_start <= lo_reg) && (lo_reg <= ent_end);
    assign len     = {1'b0, ent_end} - {1'b0, ent_start} + 1'b1;
    assign clear   = ctl.eval && ctl.ent_valid && !query_reg && meet;

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            query_reg <= query;
            lo_reg    <= lo;
            hi_reg    <= hi;
            m_lo_reg  <= lo;
            m_hi_reg  <= hi;
        end
        else if (clear)
        begin
            if (ent_start < m_lo_reg)
            begin
                m_lo_reg <= ent_start;
            end
            if (ent_end > m_hi_reg)
            begin
                m_hi_reg <= ent_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            removed_reg    <= '0;
            cleared_reg    <= '0;
        end
        else if (ctl.start)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            removed_reg    <= '0;
            cleared_reg    <= '0;
        end
        else if (ctl.eval)
        begin
            if (query_reg && ctl.ent_valid && in_span)
            begin
                hit_reg <= 1'b1;
            end
            if (clear)
            begin
                removed_reg <= removed_reg + len;
                cleared_reg <= cleared_reg + 1'b1;
            end
            // lowest slot that is free once this pass is through
            if (!free_found_reg && (!ctl.ent_valid || clear))
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= ctl.idx;
            end
        end
    end

    assign stat.hit        = hit_reg;
    assign stat.free_found = free_found_reg;
    assign stat.free_idx   = free_idx_reg;
    assign stat.m_lo       = m_lo_reg;
    assign stat.m_hi       = m_hi_reg;
    assign stat.removed    = removed_reg;
    assign stat.cleared    = cleared_reg;

endmodule

`default_nettype wire

### sv/ius_checker.sv
// port-level checks for the interval union set unit, bound to the top level
// depends on ius_pkg, ius_if and the assertion macro header
`default_nettype none
`include "interval_union_set_unit_defines.svh"

module ius_checker import ius_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic       rsp_covered,
    input wire cnt_t       rsp_range_count,
    input wire logic [1:0] rsp_status
);

    localparam cnt_t FULL_COUNT = cnt_t'(MAX_RANGES);

    logic full_rsp;
    logic flagged_rsp;

    assign full_rsp    = rsp_valid && (rsp_status == STATUS_FULL);
    assign flagged_rsp = rsp_valid && (rsp_status != STATUS_OK);

    `IUS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `IUS_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    `IUS_ASSERT_IMP(a_full_count, full_rsp, rsp_range_count == FULL_COUNT)
    `IUS_ASSERT_IMP(a_covered_ok_only, flagged_rsp, !rsp_covered)

endmodule

bind interval_union_set_unit ius_checker u_ius_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_covered     (rsp.covered),
    .rsp_range_count (rsp.range_count),
    .rsp_status      (rsp.status)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for interval_union_set_unit: directed corners, windowed random traffic,
// back-to-back items and a long output stall, checked against an in-bench range table
// depends on ius_pkg, ius_if and the unit itself
module tb;
    import ius_pkg::*;

    localparam coord_t COORD_MAX     = {COORD_BITS{1'b1}};
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     SETTLE_CYCLES = 2 * MAX_RANGES + 8;
    localparam int     PRINT_LIMIT   = 40;

    typedef struct
    {
        logic    covered;
        sum_t    total;
        cnt_t    count;
        status_t status;
    } outcome_t;

    logic clk;
    logic rst_n;

    ius_req_if req_ch ();
    ius_rsp_if rsp_ch ();

    interval_union_set_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // expected contents of the range table
    coord_t span_lo [MAX_RANGES];
    coord_t span_hi [MAX_RANGES];
    bit     span_used [MAX_RANGES];
    sum_t   span_sum;

    outcome_t pending_results [$];

    int err_count;
    int n_checked;
    int n_insert;
    int n_absorbed;
    int n_full;
    int n_reversed;
    int n_query;
    int n_hit;
    bit idle_on;
    int rsp_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int table_fill();
        int n;
        n = 0;
        for (int k = 0; k < MAX_RANGES; k++)
            if (span_used[k])
                n++;
        return n;
    endfunction

    // overlapping or directly adjacent
    function automatic bit spans_touch(int k, coord_t lo, coord_t hi);
        int unsigned s, e, l, h;
        s = 32'(span_lo[k]);
        e = 32'(span_hi[k]);
        l = 32'(lo);
        h = 32'(hi);
        return span_used[k] && s <= h + 1 && e + 1 >= l;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("mismatch at %0t ns, result %0d: %s got %0d expected %0d",
                     $time, n_checked, what, got, want);
    endtask

    task automatic apply_to_table(input op_t op, input coord_t lo, input coord_t hi,
                                  output outcome_t res);
        int unsigned m_lo, m_hi;
        bit touched;
        int free_slot;
        res.covered = 1'b0;
        res.status  = STATUS_OK;
        m_lo = 32'(lo);
        m_hi = 32'(hi);
        touched = 1'b0;
        free_slot = -1;
        if (op == OP_QUERY)
        begin
            n_query++;
            for (int k = 0; k < MAX_RANGES; k++)
                if (span_used[k] && lo >= span_lo[k] && lo <= span_hi[k])
                    res.covered = 1'b1;
            if (res.covered)
                n_hit++;
        end
        else if (lo > hi)
        begin
            n_reversed++;
            res.status = STATUS_REVERSED;
        end
        else
        begin
            n_insert++;
            for (int k = 0; k < MAX_RANGES; k++)
                if (spans_touch(k, lo, hi))
                    touched = 1'b1;
            if (!touched && table_fill() >= MAX_RANGES)
            begin
                n_full++;
                res.status = STATUS_FULL;
            end
            else
            begin
                for (int k = 0; k < MAX_RANGES; k++)
                begin
                    if (spans_touch(k, lo, hi))
                    begin
                        if (32'(span_lo[k]) < m_lo)
                            m_lo = 32'(span_lo[k]);
                        if (32'(span_hi[k]) > m_hi)
                            m_hi = 32'(span_hi[k]);
                        span_sum = span_sum - sum_t'(span_hi[k] - span_lo[k] + 1);
                        span_used[k] = 1'b0;
                        n_absorbed++;
                    end
                end
                for (int k = 0; k < MAX_RANGES; k++)
                    if (!span_used[k] && free_slot < 0)
                        free_slot = k;
                span_lo[free_slot] = coord_t'(m_lo);
                span_hi[free_slot] = coord_t'(m_hi);
                span_used[free_slot] = 1'b1;
                span_sum = span_sum + sum_t'(m_hi - m_lo + 1);
            end
        end
        res.total = span_sum;
        res.count = cnt_t'(table_fill());
    endtask

    // entered right after an accept edge, returns at the edge that takes the item
    task automatic send_item(input op_t op, input coord_t lo, input coord_t hi);
        int gap;
        outcome_t res;
        gap = idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.lo        <= lo;
        req_ch.hi        <= hi;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_to_table(op, lo, hi, res);
        pending_results = {pending_results, res};
    endtask

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin
        int ready_gap;
        ready_gap = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold--;
            end
            else if (!idle_on)
                rsp_ch.ready <= 1'b1;
            else if (ready_gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                ready_gap--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_checked++;
            if (pending_results.size() == 0)
                report_mismatch("result with no item pending, range_count",
                                longint'(rsp_ch.range_count), 0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.covered !== want.covered)
                    report_mismatch("covered", longint'(rsp_ch.covered),
                                    longint'(want.covered));
                if (rsp_ch.total_covered !== want.total)
                    report_mismatch("total_covered", longint'(rsp_ch.total_covered),
                                    longint'(want.total));
                if (rsp_ch.range_count !== want.count)
                    report_mismatch("range_count", longint'(rsp_ch.range_count),
                                    longint'(want.count));
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", longint'(rsp_ch.status),
                                    longint'(want.status));
            end
        end
    end

    task automatic test_directed_corners();
        send_item(OP_QUERY, '0, COORD_MAX);
        send_item(OP_INSERT, COORD_MAX, '0);
        // fill every slot with isolated two-point ranges
        for (int k = 0; k < MAX_RANGES - 1; k++)
            send_item(OP_INSERT, coord_t'(k * 4), coord_t'(k * 4 + 1));
        send_item(OP_INSERT, coord_t'(COORD_MAX - 1), COORD_MAX);
        send_item(OP_INSERT, coord_t'(100), coord_t'(200));
        send_item(OP_QUERY, COORD_MAX, '0);
        send_item(OP_QUERY, coord_t'(3), coord_t'(5));
        send_item(OP_QUERY, '0, COORD_MAX);
        // bridges the gap between two neighbors while the table is full
        send_item(OP_INSERT, coord_t'(2), coord_t'(3));
        send_item(OP_INSERT, coord_t'(9), coord_t'(9));
        send_item(OP_INSERT, '0, COORD_MAX);
        send_item(OP_QUERY, coord_t'(12345), COORD_MAX);
    endtask

    task automatic test_random_mix(input int n_items);
        coord_t base, lo, hi, mn, mx;
        op_t op;
        int wspan, left_in_window, r, k;
        int used_idx [$];
        left_in_window = 0;
        base = '0;
        wspan = 255;
        repeat (n_items)
        begin
            if (left_in_window == 0)
            begin
                // fold the whole table into one range now and then
                if (table_fill() >= 10 && $urandom_range(0, 1) == 1)
                begin
                    mn = COORD_MAX;
                    mx = '0;
                    for (int j = 0; j < MAX_RANGES; j++)
                    begin
                        if (span_used[j] && span_lo[j] < mn)
                            mn = span_lo[j];
                        if (span_used[j] && span_hi[j] > mx)
                            mx = span_hi[j];
                    end
                    send_item(OP_INSERT, mn, mx);
                end
                case ($urandom_range(0, 2))
                    0: wspan = 63;
                    1: wspan = 255;
                    default: wspan = 1023;
                endcase
                base = coord_t'($urandom_range(0, COORD_MAX - 2048));
                left_in_window = $urandom_range(20, 60);
            end
            left_in_window--;
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                lo = coord_t'(base + $urandom_range(0, wspan));
                if ($urandom_range(0, 3) == 0)
                    hi = coord_t'(lo + $urandom_range(0, wspan / 4));
                else
                    hi = coord_t'(lo + $urandom_range(0, 3));
                send_item(OP_INSERT, lo, hi);
            end
            else if (r < 60)
            begin
                // probe just inside and just outside a stored range
                used_idx.delete();
                for (int j = 0; j < MAX_RANGES; j++)
                    if (span_used[j])
                        used_idx = {used_idx, j};
                lo = base;
                if (used_idx.size() > 0)
                begin
                    k = used_idx[$urandom_range(0, used_idx.size() - 1)];
                    case ($urandom_range(0, 3))
                        0: lo = (span_lo[k] > 0) ? coord_t'(span_lo[k] - 1) : span_lo[k];
                        1: lo = span_lo[k];
                        2: lo = span_hi[k];
                        default:
                            lo = (span_hi[k] < COORD_MAX) ? coord_t'(span_hi[k] + 1)
                                                          : span_hi[k];
                    endcase
                end
                send_item(OP_QUERY, lo, coord_t'($urandom_range(0, COORD_MAX)));
            end
            else if (r < 80)
                send_item(OP_QUERY, coord_t'(base + $urandom_range(0, wspan)),
                          coord_t'($urandom_range(0, COORD_MAX)));
            else if (r < 88)
            begin
                lo = coord_t'($urandom_range(1, COORD_MAX));
                send_item(OP_INSERT, lo, coord_t'($urandom_range(0, lo - 1)));
            end
            else if (r < 96)
            begin
                op = op_t'($urandom_range(0, 1));
                send_item(op, coord_t'($urandom_range(0, COORD_MAX)),
                          coord_t'($urandom_range(0, COORD_MAX)));
            end
            else
                send_item(OP_INSERT, base, coord_t'(base + wspan));
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        idle_on = 1'b0;
        test_random_mix(n_items);
        idle_on = 1'b1;
    endtask

    // result side holds off while items keep coming, so the input stalls
    task automatic test_output_backpressure(input int n_items);
        idle_on = 1'b0;
        rsp_hold = 300;
        test_random_mix(n_items);
        idle_on = 1'b1;
    endtask

    task automatic finish_run();
        int waited;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() > 0)
            report_mismatch("results never returned, count", 0,
                            longint'(pending_results.size()));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.lo = '0;
        req_ch.hi = '0;
        idle_on = 1'b1;
        rsp_hold = 0;
        span_sum = '0;
        for (int k = 0; k < MAX_RANGES; k++)
        begin
            span_lo[k] = '0;
            span_hi[k] = '0;
            span_used[k] = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_mix(480);
        test_back_to_back(60);
        test_output_backpressure(40);
        finish_run();

        $display("inserts %0d (%0d stored ranges absorbed, %0d dropped on a full table)",
                 n_insert, n_absorbed, n_full);
        $display("%0d reversed, queries %0d with %0d hits; %0d results checked, %0d mismatches",
                 n_reversed, n_query, n_hit, n_checked, err_count);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
